FILE: rtl/dse_pkg.sv
// ----------------------------------------------------------------------------
// dse_pkg
// Shared types and fixed constants for the disjoint-set engine: operation and
// status codes, sequencer states and the result word carried to the output.
// ----------------------------------------------------------------------------
package dse_pkg;

    localparam int HANDLE_W = 10;
    localparam int LEN_W    = 32;
    localparam int RANK_W   = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_FIND  = 2'd1,
        OP_UNITE = 2'd2,
        OP_PIN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_HOP,
        S_LINK,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] new_handle;
        logic [HANDLE_W-1:0] root;
        logic                root_pinned;
        logic [LEN_W-1:0]    node_length;
        logic                merged;
    } result_t;

endpackage

FILE: rtl/dse_ram.sv
// ----------------------------------------------------------------------------
// dse_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered. Contents are not reset.
// ----------------------------------------------------------------------------
module dse_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 15
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // registered read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/dse_seq.sv
// ----------------------------------------------------------------------------
// dse_seq
// Operation sequencer: allocates nodes, walks parent chains with path halving
// through the node RAM, links roots by rank and builds the result word.
// ----------------------------------------------------------------------------
module dse_seq #(
    parameter int MAX_NODES = 1024,
    parameter int LEN_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command word
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  dse_pkg::op_t                   cmd_op,
    input  logic [dse_pkg::HANDLE_W-1:0]   cmd_a,
    input  logic [dse_pkg::HANDLE_W-1:0]   cmd_b,
    input  logic [dse_pkg::LEN_W-1:0]      cmd_len,
    // finished result word
    output logic                           done_valid,
    input  logic                           done_ready,
    output dse_pkg::result_t               done_word,
    // node RAM {parent, rank, pinned}
    output logic                           node_re,
    output logic [$clog2(MAX_NODES)-1:0]   node_raddr,
    input  logic [$clog2(MAX_NODES)+dse_pkg::RANK_W:0] node_rdata,
    output logic                           node_we,
    output logic [$clog2(MAX_NODES)-1:0]   node_waddr,
    output logic [$clog2(MAX_NODES)+dse_pkg::RANK_W:0] node_wdata,
    // length RAM
    output logic                           len_re,
    output logic                           len_we,
    output logic [$clog2(MAX_NODES)-1:0]   len_addr,
    input  logic [((LEN_BITS < 32) ? LEN_BITS : 32)-1:0] len_rdata,
    output logic [((LEN_BITS < 32) ? LEN_BITS : 32)-1:0] len_wdata
);

    import dse_pkg::*;

    localparam int IDX_W   = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int CMP_W   = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
    localparam int REC_W   = IDX_W + RANK_W + 1;
    localparam int SW      = (LEN_BITS < 32) ? LEN_BITS : 32;
    localparam int PAR_LSB = RANK_W + 1;

    seq_state_t        state_reg, state_next;
    op_t               op_reg, op_next;
    logic [IDX_W-1:0]  b_reg, b_next;
    logic [IDX_W-1:0]  h_reg, h_next;
    logic [IDX_W-1:0]  p_reg, p_next;
    logic [REC_W-1:0]  hrec_reg, hrec_next;
    logic [IDX_W-1:0]  ra_reg, ra_next;
    logic [REC_W-1:0]  rarec_reg, rarec_next;
    logic              phase_reg, phase_next;
    logic [IDX_W-1:0]  win_reg, win_next;
    logic [REC_W-1:0]  winrec_reg, winrec_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    result_t           res_reg, res_next;

    logic [IDX_W-1:0]  rd_parent;
    logic              found;
    logic [IDX_W-1:0]  fr;
    logic [REC_W-1:0]  frec;
    logic              a_ok, b_ok, bad;
    logic              swap, tie;
    logic [IDX_W-1:0]  w_idx, l_idx;
    logic [REC_W-1:0]  w_rec, l_rec;
    logic [RANK_W-1:0] w_rank, new_rank;

    assign rd_parent = node_rdata[REC_W-1:PAR_LSB];

    // root detection on the word just read
    always_comb
    begin
        found = 1'b0;
        fr    = h_reg;
        frec  = node_rdata;
        case (state_reg)
            S_LOOK:
            begin
                found = (rd_parent == h_reg);
                fr    = h_reg;
            end
            S_HOP:
            begin
                found = (rd_parent == p_reg);
                fr    = p_reg;
            end
            default:
            begin
                found = 1'b0;
            end
        endcase
    end

    // handle range checks
    assign a_ok = (CMP_W'(cmd_a) < CMP_W'(cnt_reg));
    assign b_ok = (CMP_W'(cmd_b) < CMP_W'(cnt_reg));
    assign bad  = !a_ok || ((cmd_op == OP_UNITE) && !b_ok);

    // link by rank: pick winner and loser, raise rank on a tie
    always_comb
    begin
        swap     = (rarec_reg[RANK_W:1] < frec[RANK_W:1]);
        tie      = (rarec_reg[RANK_W:1] == frec[RANK_W:1]);
        w_idx    = swap ? fr : ra_reg;
        l_idx    = swap ? ra_reg : fr;
        w_rec    = swap ? frec : rarec_reg;
        l_rec    = swap ? rarec_reg : frec;
        w_rank   = w_rec[RANK_W:1];
        new_rank = (tie && (w_rank != RANK_MAX)) ? w_rank + RANK_W'(1) : w_rank;
    end

    // next state and memory control
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        b_next      = b_reg;
        h_next      = h_reg;
        p_next      = p_reg;
        hrec_next   = hrec_reg;
        ra_next     = ra_reg;
        rarec_next  = rarec_reg;
        phase_next  = phase_reg;
        win_next    = win_reg;
        winrec_next = winrec_reg;
        cnt_next    = cnt_reg;
        res_next    = res_reg;
        node_re     = 1'b0;
        node_raddr  = h_reg;
        node_we     = 1'b0;
        node_waddr  = h_reg;
        node_wdata  = hrec_reg;
        len_re      = 1'b0;
        len_we      = 1'b0;
        len_addr    = IDX_W'(cmd_a);
        len_wdata   = SW'(cmd_len);
        cmd_ready   = 1'b0;
        done_valid  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next  = cmd_op;
                    res_next = '0;
                    if (cmd_op == OP_ADD)
                    begin
                        if (cnt_reg == CNT_W'(MAX_NODES))
                        begin
                            res_next.status = STAT_FULL;
                        end
                        else
                        begin
                            // allocate a fresh singleton
                            node_we    = 1'b1;
                            node_waddr = IDX_W'(cnt_reg);
                            node_wdata = {IDX_W'(cnt_reg), {RANK_W{1'b0}}, 1'b0};
                            len_we     = 1'b1;
                            len_addr   = IDX_W'(cnt_reg);
                            cnt_next   = cnt_reg + CNT_W'(1);
                            res_next.new_handle  = HANDLE_W'(cnt_reg);
                            res_next.root        = HANDLE_W'(cnt_reg);
                            res_next.node_length = LEN_W'(SW'(cmd_len));
                        end
                        state_next = S_DONE;
                    end
                    else if (bad)
                    begin
                        res_next.status = STAT_BAD;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        // start the walk from the first handle
                        node_re    = 1'b1;
                        node_raddr = IDX_W'(cmd_a);
                        len_re     = 1'b1;
                        h_next     = IDX_W'(cmd_a);
                        b_next     = IDX_W'(cmd_b);
                        phase_next = 1'b0;
                        state_next = S_LOOK;
                    end
                end
            end

            S_LOOK, S_HOP:
            begin
                if (!found)
                begin
                    if (state_reg == S_LOOK)
                    begin
                        // fetch the parent
                        node_re    = 1'b1;
                        node_raddr = rd_parent;
                        p_next     = rd_parent;
                        hrec_next  = node_rdata;
                        state_next = S_HOP;
                    end
                    else
                    begin
                        // halve: point h at its grandparent, continue there
                        node_we    = 1'b1;
                        node_waddr = h_reg;
                        node_wdata = {rd_parent, hrec_reg[RANK_W:0]};
                        node_re    = 1'b1;
                        node_raddr = rd_parent;
                        h_next     = rd_parent;
                        state_next = S_LOOK;
                    end
                end
                else if (!phase_reg)
                begin
                    case (op_reg)
                        OP_FIND:
                        begin
                            res_next.root        = HANDLE_W'(fr);
                            res_next.root_pinned = frec[0];
                            res_next.node_length = LEN_W'(len_rdata);
                            state_next           = S_DONE;
                        end
                        OP_PIN:
                        begin
                            node_we              = 1'b1;
                            node_waddr           = fr;
                            node_wdata           = {frec[REC_W-1:1], 1'b1};
                            res_next.root        = HANDLE_W'(fr);
                            res_next.root_pinned = 1'b1;
                            state_next           = S_DONE;
                        end
                        OP_UNITE:
                        begin
                            // keep first root, walk the second handle
                            ra_next    = fr;
                            rarec_next = frec;
                            node_re    = 1'b1;
                            node_raddr = b_reg;
                            h_next     = b_reg;
                            phase_next = 1'b1;
                            state_next = S_LOOK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                else if (fr == ra_reg)
                begin
                    // same set: no link
                    res_next.root        = HANDLE_W'(fr);
                    res_next.root_pinned = frec[0];
                    state_next           = S_DONE;
                end
                else
                begin
                    // hang the loser under the winner
                    node_we     = 1'b1;
                    node_waddr  = l_idx;
                    node_wdata  = {w_idx, l_rec[RANK_W:0]};
                    win_next    = w_idx;
                    winrec_next = {w_idx, new_rank, rarec_reg[0] | frec[0]};
                    state_next  = S_LINK;
                end
            end

            S_LINK:
            begin
                // update the winner's rank and pinned flag
                node_we              = 1'b1;
                node_waddr           = win_reg;
                node_wdata           = winrec_reg;
                res_next.root        = HANDLE_W'(win_reg);
                res_next.root_pinned = winrec_reg[0];
                res_next.merged      = 1'b1;
                state_next           = S_DONE;
            end

            S_DONE:
            begin
                done_valid = 1'b1;
                if (done_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done_word = res_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    // walk and result payload
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        b_reg      <= b_next;
        h_reg      <= h_next;
        p_reg      <= p_next;
        hrec_reg   <= hrec_next;
        ra_reg     <= ra_next;
        rarec_reg  <= rarec_next;
        win_reg    <= win_next;
        winrec_reg <= winrec_next;
        res_reg    <= res_next;
    end

`ifndef SYNTHESIS
    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (node_we && node_re) |-> (node_waddr != node_raddr))
        else $error("node RAM read and write hit the same entry");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_NODES))
        else $error("node count above table size");

    a_write_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        node_we |-> (CNT_W'(node_waddr) <= cnt_reg))
        else $error("node RAM write beyond allocated handles");

    a_link_follows_loser: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |-> $past(node_we))
        else $error("winner update without loser link");

    a_merged_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_valid && res_reg.merged) |-> (res_reg.status == STAT_OK))
        else $error("merged result with error status");
`endif

endmodule

FILE: rtl/disjoint_set_engine_unit.sv
// ----------------------------------------------------------------------------
// disjoint_set_engine_unit
// Union-find table engine: add, find with path halving, unite by rank, pin.
// ----------------------------------------------------------------------------
// Flow: add and rejected words go from idle straight to the done state; find
// and pin walk the chain to the root through alternating look and hop states;
// unite walks both chains and adds a link state on merge. Words are taken one at
// a time, in idle only; the output register frees the sequencer for the next word
// once it takes the finished word, which waits in done while that register is full.
// Reset: node count cleared; RAM contents are not cleared and need no pass.
module disjoint_set_engine_unit #(
    parameter int MAX_NODES = 1024,
    parameter int LEN_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [1:0]                    op,
    input  logic [dse_pkg::HANDLE_W-1:0]  node_a,
    input  logic [dse_pkg::HANDLE_W-1:0]  node_b,
    input  logic [dse_pkg::LEN_W-1:0]     length,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [1:0]                    status,
    output logic [dse_pkg::HANDLE_W-1:0]  new_handle,
    output logic [dse_pkg::HANDLE_W-1:0]  root,
    output logic                          root_pinned,
    output logic [dse_pkg::LEN_W-1:0]     node_length,
    output logic                          merged
);

    import dse_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int REC_W = IDX_W + RANK_W + 1;
    localparam int SW    = (LEN_BITS < 32) ? LEN_BITS : 32;

    logic              node_re, node_we;
    logic [IDX_W-1:0]  node_raddr, node_waddr;
    logic [REC_W-1:0]  node_rdata, node_wdata;
    logic              len_re, len_we;
    logic [IDX_W-1:0]  len_addr;
    logic [SW-1:0]     len_rdata, len_wdata;
    logic              done_valid, done_ready;
    result_t           done_word;
    result_t           out_reg;
    logic              out_valid_reg, out_valid_next;

    dse_seq #(
        .MAX_NODES (MAX_NODES),
        .LEN_BITS  (LEN_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_op     (op_t'(op)),
        .cmd_a      (node_a),
        .cmd_b      (node_b),
        .cmd_len    (length),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .done_word  (done_word),
        .node_re    (node_re),
        .node_raddr (node_raddr),
        .node_rdata (node_rdata),
        .node_we    (node_we),
        .node_waddr (node_waddr),
        .node_wdata (node_wdata),
        .len_re     (len_re),
        .len_we     (len_we),
        .len_addr   (len_addr),
        .len_rdata  (len_rdata),
        .len_wdata  (len_wdata)
    );

    dse_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (REC_W)
    ) u_node_ram (
        .clk     (clk),
        .rd_en   (node_re),
        .rd_addr (node_raddr),
        .rd_data (node_rdata),
        .wr_en   (node_we),
        .wr_addr (node_waddr),
        .wr_data (node_wdata)
    );

    dse_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (SW)
    ) u_len_ram (
        .clk     (clk),
        .rd_en   (len_re),
        .rd_addr (len_addr),
        .rd_data (len_rdata),
        .wr_en   (len_we),
        .wr_addr (len_addr),
        .wr_data (len_wdata)
    );

    // take a finished word when the output stage is empty or draining
    assign done_ready = !out_valid_reg || res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done_valid && done_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result word
    always_ff @(posedge clk)
    begin
        if (done_valid && done_ready)
        begin
            out_reg <= done_word;
        end
    end

    assign res_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign new_handle  = out_reg.new_handle;
    assign root        = out_reg.root;
    assign root_pinned = out_reg.root_pinned;
    assign node_length = out_reg.node_length;
    assign merged      = out_reg.merged;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for disjoint_set_engine_unit. A software copy of the
// union-find table (path halving, union by rank, pinned flags) predicts every
// result word; a monitor compares each accepted result with the oldest
// prediction. Directed words cover empty-table rejections and the basic
// operations, then random traffic grows the table, fills it and keeps working
// on the full table, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dse_pkg::*;

    localparam int MAX_NODES   = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 40;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cmd_valid   = 1'b0;
    logic                cmd_ready;
    logic [1:0]          op          = '0;
    logic [HANDLE_W-1:0] node_a      = '0;
    logic [HANDLE_W-1:0] node_b      = '0;
    logic [LEN_W-1:0]    length      = '0;
    logic                res_valid;
    logic                res_ready   = 1'b0;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] new_handle;
    logic [HANDLE_W-1:0] root;
    logic                root_pinned;
    logic [LEN_W-1:0]    node_length;
    logic                merged;

    // Shadow copy of the node table
    logic [HANDLE_W-1:0] parent_tbl [MAX_NODES];
    logic [RANK_W-1:0]   rank_tbl   [MAX_NODES];
    logic                pinned_tbl [MAX_NODES];
    logic [LEN_W-1:0]    length_tbl [MAX_NODES];
    int                  node_total = 0;

    result_t due_results [$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int words_sent      = 0;
    int cycle_count     = 0;
    int burst_left      = 0;
    int op_seen [4]     = '{0, 0, 0, 0};
    int merge_count     = 0;
    int full_count      = 0;
    int bad_count       = 0;

    disjoint_set_engine_unit #(
        .MAX_NODES (MAX_NODES),
        .LEN_BITS  (LEN_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .op          (op),
        .node_a      (node_a),
        .node_b      (node_b),
        .length      (length),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .status      (status),
        .new_handle  (new_handle),
        .root        (root),
        .root_pinned (root_pinned),
        .node_length (node_length),
        .merged      (merged)
    );

    always #10 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Walk to the root, pointing each visited node at its grandparent
    function automatic logic [HANDLE_W-1:0] find_root(logic [HANDLE_W-1:0] h);
        int hops = 0;
        while (parent_tbl[h] != h && hops < MAX_NODES)
        begin
            parent_tbl[h] = parent_tbl[parent_tbl[h]];
            h = parent_tbl[h];
            hops++;
        end
        return h;
    endfunction

    // Apply one word to the shadow table and return the result it must produce
    function automatic result_t predict_table_op(op_t o, logic [HANDLE_W-1:0] a,
                                                 logic [HANDLE_W-1:0] b,
                                                 logic [LEN_W-1:0] len);
        result_t             r;
        logic [HANDLE_W-1:0] ra;
        logic [HANDLE_W-1:0] rb;
        logic [HANDLE_W-1:0] t;
        r = '0;
        op_seen[o]++;
        if (o == OP_ADD)
        begin
            if (node_total >= MAX_NODES)
            begin
                r.status = STAT_FULL;
                full_count++;
                return r;
            end
            t = node_total[HANDLE_W-1:0];
            parent_tbl[t] = t;
            rank_tbl[t]   = '0;
            pinned_tbl[t] = 1'b0;
            length_tbl[t] = len;
            node_total++;
            r.new_handle  = t;
            r.root        = t;
            r.node_length = len;
            return r;
        end
        if (a >= node_total || (o == OP_UNITE && b >= node_total))
        begin
            r.status = STAT_BAD;
            bad_count++;
            return r;
        end
        ra = find_root(a);
        if (o == OP_FIND)
        begin
            r.root        = ra;
            r.root_pinned = pinned_tbl[ra];
            r.node_length = length_tbl[a];
            return r;
        end
        if (o == OP_PIN)
        begin
            pinned_tbl[ra] = 1'b1;
            r.root         = ra;
            r.root_pinned  = 1'b1;
            return r;
        end
        rb = find_root(b);
        if (ra != rb)
        begin
            // Higher rank survives; on a tie the first root survives
            if (rank_tbl[ra] < rank_tbl[rb])
            begin
                t  = ra;
                ra = rb;
                rb = t;
            end
            parent_tbl[rb] = ra;
            if (rank_tbl[ra] == rank_tbl[rb] && rank_tbl[ra] != RANK_MAX)
                rank_tbl[ra] = rank_tbl[ra] + 1'b1;
            pinned_tbl[ra] = pinned_tbl[ra] | pinned_tbl[rb];
            r.merged = 1'b1;
            merge_count++;
        end
        r.root        = ra;
        r.root_pinned = pinned_tbl[ra];
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] result %0d %s: expected %0h, got %0h",
                         $realtime, results_checked, name, want, got);
        end
    endtask

    // Check each accepted result word against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (due_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] result word with nothing expected", $realtime);
            end
            else
            begin
                want = due_results.pop_front();
                compare_field("status",      want.status,      status);
                compare_field("new_handle",  want.new_handle,  new_handle);
                compare_field("root",        want.root,        root);
                compare_field("root_pinned", want.root_pinned, root_pinned);
                compare_field("node_length", want.node_length, node_length);
                compare_field("merged",      want.merged,      merged);
                results_checked++;
            end
        end
    end

    // Receiver back-pressure: switch between stall styles every so often
    int stall_mode = 0;
    int mode_left  = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(50, 300);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0:       res_ready <= 1'b1;
                1:       res_ready <= ($urandom_range(0, 3) != 0);
                2:       res_ready <= ($urandom_range(0, 3) == 0);
                default: res_ready <= (cycle_count % 9) > 5;
            endcase
        end
    end

    // Sender pacing: bursts of back-to-back words, random gaps in between
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 20);
        end
    endtask

    // Present one word, hold it until accepted, then record its prediction
    task automatic send_word(op_t o, logic [HANDLE_W-1:0] a, logic [HANDLE_W-1:0] b,
                             logic [LEN_W-1:0] len);
        result_t predicted;
        cmd_valid <= 1'b1;
        op        <= o;
        node_a    <= a;
        node_b    <= b;
        length    <= len;
        do
            @(posedge clk);
        while (!cmd_ready);
        predicted = predict_table_op(o, a, b, len);
        due_results.insert(due_results.size(), predicted);
        words_sent++;
        pace_sender();
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic wait_drain();
        if (cmd_valid)
            cmd_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly live handles, now and then one beyond the allocated range
    function automatic logic [HANDLE_W-1:0] pick_handle();
        if (node_total == 0)
            return HANDLE_W'($urandom);
        if (node_total < MAX_NODES && $urandom_range(0, 15) == 0)
            return HANDLE_W'($urandom_range(node_total, MAX_NODES - 1));
        return HANDLE_W'($urandom_range(0, node_total - 1));
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return LEN_W'($urandom);
        endcase
    endfunction

    task automatic send_random_word(int add_pct);
        op_t o;
        int  roll;
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
            o = OP_ADD;
        else
        begin
            roll = $urandom_range(0, 9);
            o = (roll < 3) ? OP_FIND : (roll < 8) ? OP_UNITE : OP_PIN;
        end
        send_word(o, pick_handle(), pick_handle(), pick_length());
    endtask

    // Every handle is unallocated while the table is empty
    task automatic test_empty_table();
        send_word(OP_FIND,  '0, '1, '1);
        send_word(OP_UNITE, '1, '0, '0);
        send_word(OP_PIN,   '0, '0, 32'h1234_5678);
        send_word(OP_FIND,  '1, '1, '0);
    endtask

    // Small hand-built forest: ties, same-set unite, halving on a chain
    task automatic test_basic_ops();
        send_word(OP_ADD,   '1, '1, '0);
        send_word(OP_ADD,   '0, '0, '1);
        send_word(OP_ADD,   '0, '0, 32'hA5A5_5A5A);
        send_word(OP_ADD,   '1, '0, 32'h0000_0001);
        send_word(OP_FIND,  10'd1, '0, '0);
        send_word(OP_PIN,   10'd0, '1, '0);
        send_word(OP_UNITE, 10'd0, 10'd1, '0);
        send_word(OP_UNITE, 10'd1, 10'd0, '0);
        send_word(OP_UNITE, 10'd2, 10'd3, '0);
        send_word(OP_UNITE, 10'd3, 10'd1, '0);
        send_word(OP_FIND,  10'd1, '0, '0);
        send_word(OP_FIND,  10'd3, '1, '0);
        send_word(OP_PIN,   10'd1, '0, '0);
        send_word(OP_FIND,  10'd4, '0, '0);
        send_word(OP_UNITE, 10'd0, '1, '0);
        send_word(OP_UNITE, 10'd512, 10'd0, '0);
        send_word(OP_PIN,   '1, '0, '0);
    endtask

    // Grow the table while mixing in plenty of finds, unites and pins
    task automatic test_random_mix();
        repeat (600) send_random_word(40);
    endtask

    // Drain once, then fill the table to its last entry
    task automatic test_table_fill();
        wait_drain();
        while (node_total < MAX_NODES)
            send_random_word(75);
    endtask

    // Adds on a full table are refused; handle 1023 is now live.
    // Rank saturation cannot be reached: 1024 nodes give rank 10 at most.
    task automatic test_full_table();
        send_word(OP_ADD,   '0, '0, '1);
        send_word(OP_ADD,   '1, '1, '0);
        send_word(OP_FIND,  '1, '0, '0);
        send_word(OP_UNITE, '1, '0, '0);
        send_word(OP_PIN,   '1, '1, '0);
        wait_drain();
        repeat (100) send_random_word(10);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_basic_ops();
        test_random_mix();
        test_table_fill();
        test_full_table();
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d words (add %0d, find %0d, unite %0d, pin %0d), %0d results checked",
                 words_sent, op_seen[OP_ADD], op_seen[OP_FIND], op_seen[OP_UNITE],
                 op_seen[OP_PIN], results_checked);
        $display("%0d merges, %0d full-table and %0d bad-handle rejections, %0d nodes",
                 merge_count, full_count, bad_count, node_total);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
